// ===== hw/rtl/dqs_pkg.sv =====
// Shared constants and codes for the double-ended queue with search.
`default_nettype none
package dqs_pkg;

  localparam int CAPACITY = 16;
  localparam int ACTION_W = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 5;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH_FRONT  = 3'd0,
    ACT_PUSH_BACK   = 3'd1,
    ACT_POP_FRONT   = 3'd2,
    ACT_POP_BACK    = 3'd3,
    ACT_SEARCH      = 3'd4
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

endpackage
`default_nettype wire

// ===== hw/rtl/dqs_if.sv =====
// Request and response channel interfaces for the double-ended queue.
`default_nettype none
interface dqs_req_if;
  logic                                valid;
  logic                                ready;
  logic        [dqs_pkg::ACTION_W-1:0] action;
  logic signed [dqs_pkg::VALUE_W-1:0]  value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

interface dqs_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [dqs_pkg::STATUS_W-1:0] status;
  logic                         found;
  logic [dqs_pkg::OCC_W-1:0]    occupancy;

  modport source (output valid, output status, output found, output occupancy, input ready);
  modport sink   (input valid, input status, input found, input occupancy, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/dqs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module dqs_ram #(
  parameter int WIDTH = dqs_pkg::VALUE_W,
  parameter int DEPTH = dqs_pkg::CAPACITY
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/double_ended_queue_with_search.sv =====
// Bounded double-ended queue of 32-bit words in a circular RAM, with key search.
//
//  channel  dir  fields                        word
//  req      in   action[2:0], value[31:0]      one request
//  rsp      out  status[1:0], found, occ[4:0]  one response per request
//
// Push and remove are handled in the idle state; the response register
// frees req.ready again once it is taken (or taken in the same cycle).
// In a search the single RAM read port delivers one stored word per cycle,
// each compared in the cycle after its read; it stops at the first hit.
// Search on an empty queue answers from the idle state with status empty.
// Reset clears the state, indices, count and valid flags; RAM contents stay undefined
// until written, and no slot is read before it has been written.
`default_nettype none
module double_ended_queue_with_search #(
  parameter int CAPACITY = dqs_pkg::CAPACITY
) (
  input wire logic  clk,
  input wire logic  rst,
  dqs_req_if.sink   req,
  dqs_rsp_if.source rsp
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_SEARCH = 2'b10
  } state_t;

  state_t                        state;
  logic [IDX_W-1:0]              front;
  logic [IDX_W-1:0]              back;
  logic [CNT_W-1:0]              count;
  logic [dqs_pkg::VALUE_W-1:0]   key;
  logic [IDX_W-1:0]              rd_slot;
  logic [CNT_W-1:0]              issue_cnt;
  logic [CNT_W-1:0]              cmp_cnt;
  logic                          rd_pend;
  logic                          out_valid;
  dqs_pkg::status_t              out_status;
  logic                          out_found;
  logic [dqs_pkg::OCC_W-1:0]     out_occ;

  logic                          accept;
  logic                          is_full;
  logic                          is_empty;
  logic [IDX_W-1:0]              front_inc;
  logic [IDX_W-1:0]              front_dec;
  logic [IDX_W-1:0]              back_inc;
  logic [IDX_W-1:0]              back_dec;
  logic [IDX_W-1:0]              rd_slot_inc;
  logic                          ram_we;
  logic [IDX_W-1:0]              ram_waddr;
  logic                          ram_re;
  logic [dqs_pkg::VALUE_W-1:0]   ram_rdata;
  logic                          hit;
  logic                          last_cmp;

  assign accept   = req.valid && req.ready;
  assign is_full  = (count == FULL_CNT);
  assign is_empty = (count == '0);

  assign front_inc   = (front == LAST_IDX) ? '0 : front + 1'b1;
  assign front_dec   = (front == '0) ? LAST_IDX : front - 1'b1;
  assign back_inc    = (back == LAST_IDX) ? '0 : back + 1'b1;
  assign back_dec    = (back == '0) ? LAST_IDX : back - 1'b1;
  assign rd_slot_inc = (rd_slot == LAST_IDX) ? '0 : rd_slot + 1'b1;

  // Writes happen only in idle and a search starts after them, so reads
  // never overlap a write to the same slot.
  assign ram_we = accept && !is_full &&
                  (req.action inside {dqs_pkg::ACT_PUSH_FRONT, dqs_pkg::ACT_PUSH_BACK});
  assign ram_waddr = (req.action == dqs_pkg::ACT_PUSH_FRONT) ? front_dec : back;
  assign ram_re    = (state == S_SEARCH) && (issue_cnt < count);

  assign hit      = rd_pend && (ram_rdata == key);
  assign last_cmp = rd_pend && ((cmp_cnt + CNT_W'(1)) == count);

  dqs_ram #(
    .WIDTH (dqs_pkg::VALUE_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (req.value),
    .re    (ram_re),
    .raddr (rd_slot),
    .rdata (ram_rdata)
  );

  assign req.ready     = (state == S_IDLE) && (!out_valid || rsp.ready);
  assign rsp.valid     = out_valid;
  assign rsp.status    = out_status;
  assign rsp.found     = out_found;
  assign rsp.occupancy = out_occ;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      front     <= '0;
      back      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
      rd_pend   <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          rd_pend <= 1'b0;
          if (accept) begin
            out_valid  <= 1'b1;
            out_status <= dqs_pkg::ST_DONE;
            out_found  <= 1'b0;
            out_occ    <= dqs_pkg::OCC_W'(count);
            case (req.action)
              dqs_pkg::ACT_PUSH_FRONT: begin
                if (is_full) begin
                  out_status <= dqs_pkg::ST_FULL;
                end else begin
                  front   <= front_dec;
                  count   <= count + CNT_W'(1);
                  out_occ <= dqs_pkg::OCC_W'(count + CNT_W'(1));
                end
              end
              dqs_pkg::ACT_PUSH_BACK: begin
                if (is_full) begin
                  out_status <= dqs_pkg::ST_FULL;
                end else begin
                  back    <= back_inc;
                  count   <= count + CNT_W'(1);
                  out_occ <= dqs_pkg::OCC_W'(count + CNT_W'(1));
                end
              end
              dqs_pkg::ACT_POP_FRONT: begin
                if (is_empty) begin
                  out_status <= dqs_pkg::ST_EMPTY;
                end else begin
                  front   <= front_inc;
                  count   <= count - CNT_W'(1);
                  out_occ <= dqs_pkg::OCC_W'(count - CNT_W'(1));
                end
              end
              dqs_pkg::ACT_POP_BACK: begin
                if (is_empty) begin
                  out_status <= dqs_pkg::ST_EMPTY;
                end else begin
                  back    <= back_dec;
                  count   <= count - CNT_W'(1);
                  out_occ <= dqs_pkg::OCC_W'(count - CNT_W'(1));
                end
              end
              dqs_pkg::ACT_SEARCH: begin
                if (is_empty) begin
                  out_status <= dqs_pkg::ST_EMPTY;
                end else begin
                  // response comes from the search loop
                  out_valid <= 1'b0;
                  state     <= S_SEARCH;
                  key       <= req.value;
                  rd_slot   <= front;
                  issue_cnt <= '0;
                  cmp_cnt   <= '0;
                end
              end
              default: ;
            endcase
          end
        end
        S_SEARCH: begin
          // read one slot per cycle, compare it in the next cycle
          if (ram_re) begin
            rd_slot   <= rd_slot_inc;
            issue_cnt <= issue_cnt + CNT_W'(1);
          end
          rd_pend <= ram_re;
          if (rd_pend) begin
            cmp_cnt <= cmp_cnt + CNT_W'(1);
          end
          if (hit || last_cmp) begin
            state      <= S_IDLE;
            rd_pend    <= 1'b0;
            out_valid  <= 1'b1;
            out_status <= dqs_pkg::ST_DONE;
            out_found  <= hit;
            out_occ    <= dqs_pkg::OCC_W'(count);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("element count above capacity");

  a_full_flag: assert property (@(posedge clk) disable iff (rst)
    (accept && is_full &&
     (req.action == dqs_pkg::ACT_PUSH_FRONT || req.action == dqs_pkg::ACT_PUSH_BACK))
    |=> (rsp.valid && rsp.status == dqs_pkg::ST_FULL && $stable(count)))
    else $error("push on full queue not flagged or not dropped");

  a_search_no_rsp: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEARCH) |-> (!out_valid && !req.ready))
    else $error("response pending or request taken during search");

  a_found_done: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.found) |-> (rsp.status == dqs_pkg::ST_DONE))
    else $error("found set with non-done status");

endmodule
`default_nettype wire

// ===== test/tb_double_ended_queue_with_search.sv =====
// Testbench for the double-ended queue with search: directed and random requests, scoreboarded.
`timescale 1ns / 100ps
module tb_double_ended_queue_with_search;

  typedef struct {
    dqs_pkg::action_t action;
    logic [31:0]      value;
  } deque_req_t;

  typedef struct packed {
    logic [dqs_pkg::STATUS_W-1:0] status;
    logic                         found;
    logic [dqs_pkg::OCC_W-1:0]    occupancy;
  } deque_rsp_t;

  logic clk = 1'b0;
  logic rst;

  dqs_req_if req_ch ();
  dqs_rsp_if rsp_ch ();

  double_ended_queue_with_search u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #5 clk = ~clk;

  deque_req_t  pending_reqs[$];
  deque_rsp_t  expected_rsps[$];
  logic [31:0] recent_vals[$];
  deque_req_t  next_req;
  int          src_idle_pct;
  int          snk_idle_pct;
  int          err_count;

  // shadow of the queue contents
  logic [31:0] shadow_store[dqs_pkg::CAPACITY];
  int          shadow_front;
  int          shadow_back;
  int          shadow_count;

  function automatic deque_rsp_t apply_request(input dqs_pkg::action_t act,
                                               input logic [31:0] key);
    deque_rsp_t r;
    int         slot;
    r.status = dqs_pkg::ST_DONE;
    r.found  = 1'b0;
    case (act)
      dqs_pkg::ACT_PUSH_FRONT: begin
        if (shadow_count >= dqs_pkg::CAPACITY) begin
          r.status = dqs_pkg::ST_FULL;
        end else begin
          shadow_front = (shadow_front + dqs_pkg::CAPACITY - 1) % dqs_pkg::CAPACITY;
          shadow_store[shadow_front] = key;
          shadow_count++;
        end
      end
      dqs_pkg::ACT_PUSH_BACK: begin
        if (shadow_count >= dqs_pkg::CAPACITY) begin
          r.status = dqs_pkg::ST_FULL;
        end else begin
          shadow_store[shadow_back] = key;
          shadow_back = (shadow_back + 1) % dqs_pkg::CAPACITY;
          shadow_count++;
        end
      end
      dqs_pkg::ACT_POP_FRONT: begin
        if (shadow_count == 0) begin
          r.status = dqs_pkg::ST_EMPTY;
        end else begin
          shadow_front = (shadow_front + 1) % dqs_pkg::CAPACITY;
          shadow_count--;
        end
      end
      dqs_pkg::ACT_POP_BACK: begin
        if (shadow_count == 0) begin
          r.status = dqs_pkg::ST_EMPTY;
        end else begin
          shadow_back = (shadow_back + dqs_pkg::CAPACITY - 1) % dqs_pkg::CAPACITY;
          shadow_count--;
        end
      end
      dqs_pkg::ACT_SEARCH: begin
        if (shadow_count == 0) begin
          r.status = dqs_pkg::ST_EMPTY;
        end else begin
          slot = shadow_front;
          for (int i = 0; i < shadow_count && !r.found; i++) begin
            if (shadow_store[slot] == key) r.found = 1'b1;
            slot = (slot + 1) % dqs_pkg::CAPACITY;
          end
        end
      end
      default: ;
    endcase
    r.occupancy = shadow_count[dqs_pkg::OCC_W-1:0];
    return r;
  endfunction

  task automatic add_req(input dqs_pkg::action_t act, input logic [31:0] v);
    deque_req_t q;
    q.action = act;
    q.value  = v;
    pending_reqs.push_back(q);
    if (act == dqs_pkg::ACT_PUSH_FRONT || act == dqs_pkg::ACT_PUSH_BACK) begin
      recent_vals.push_back(v);
      if (recent_vals.size() > 24) void'(recent_vals.pop_front());
    end
  endtask

  // extremes and small values so that duplicates and hits are common
  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      4, 5, 6: return 32'($urandom_range(7));
      default: return $urandom;
    endcase
  endfunction

  // push-heavy, balanced and pop-heavy stretches walk the queue between full and empty
  task automatic add_random_reqs(input int n);
    int push_pct;
    int r;
    logic [31:0] key;
    push_pct = 50;
    for (int k = 0; k < n; k++) begin
      if (k % 40 == 0) begin
        case ($urandom_range(2))
          0: push_pct = 85;
          1: push_pct = 50;
          default: push_pct = 15;
        endcase
      end
      r = $urandom_range(99);
      if (r < 20) begin
        if (recent_vals.size() != 0 && $urandom_range(9) < 6)
          key = recent_vals[$urandom_range(recent_vals.size() - 1)];
        else
          key = pick_value();
        add_req(dqs_pkg::ACT_SEARCH, key);
      end else if ($urandom_range(99) < push_pct) begin
        add_req($urandom_range(1) ? dqs_pkg::ACT_PUSH_BACK : dqs_pkg::ACT_PUSH_FRONT,
                pick_value());
      end else begin
        add_req($urandom_range(1) ? dqs_pkg::ACT_POP_BACK : dqs_pkg::ACT_POP_FRONT,
                pick_value());
      end
    end
  endtask

  // request driver: a word leaves the queue only once the previous one was taken
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready)
        expected_rsps.push_back(apply_request(dqs_pkg::action_t'(req_ch.action),
                                              req_ch.value));
      if (!req_ch.valid || req_ch.ready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          next_req = pending_reqs.pop_front();
          req_ch.valid  <= 1'b1;
          req_ch.action <= next_req.action;
          req_ch.value  <= next_req.value;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // response monitor and checker
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_rsps.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("%0t: unexpected response status=%0d found=%0b occupancy=%0d",
                     $realtime, rsp_ch.status, rsp_ch.found, rsp_ch.occupancy);
        end else begin
          deque_rsp_t exp_rsp;
          exp_rsp = expected_rsps.pop_front();
          if (rsp_ch.status !== exp_rsp.status || rsp_ch.found !== exp_rsp.found ||
              rsp_ch.occupancy !== exp_rsp.occupancy) begin
            err_count++;
            if (err_count <= 10)
              $display({"%0t: mismatch expected status=%0d found=%0b occupancy=%0d,",
                        " got status=%0d found=%0b occupancy=%0d"},
                       $realtime, exp_rsp.status, exp_rsp.found, exp_rsp.occupancy,
                       rsp_ch.status, rsp_ch.found, rsp_ch.occupancy);
          end
        end
      end
      rsp_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  initial begin
    rst           = 1'b1;
    req_ch.valid  = 1'b0;
    req_ch.action = dqs_pkg::ACT_PUSH_FRONT;
    req_ch.value  = '0;
    rsp_ch.ready  = 1'b0;
    err_count     = 0;
    shadow_front  = 0;
    shadow_back   = 0;
    shadow_count  = 0;
    src_idle_pct  = 11;
    snk_idle_pct  = 82;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: empty cases, extremes, hits and misses, full queue
    add_req(dqs_pkg::ACT_POP_FRONT, 32'h0);
    add_req(dqs_pkg::ACT_POP_BACK, 32'hFFFF_FFFF);
    add_req(dqs_pkg::ACT_SEARCH, 32'h0);
    add_req(dqs_pkg::ACT_PUSH_FRONT, 32'h7FFF_FFFF);
    add_req(dqs_pkg::ACT_PUSH_BACK, 32'h8000_0000);
    add_req(dqs_pkg::ACT_PUSH_FRONT, 32'hFFFF_FFFF);
    add_req(dqs_pkg::ACT_PUSH_BACK, 32'h0);
    add_req(dqs_pkg::ACT_SEARCH, 32'h8000_0000);
    add_req(dqs_pkg::ACT_SEARCH, 32'h7FFF_FFFF);
    add_req(dqs_pkg::ACT_SEARCH, 32'h0001_2345);
    for (int k = 0; k < dqs_pkg::CAPACITY - 4; k++)
      add_req(k % 2 ? dqs_pkg::ACT_PUSH_FRONT : dqs_pkg::ACT_PUSH_BACK, 32'h5A5A_0000 + k);
    add_req(dqs_pkg::ACT_PUSH_FRONT, 32'h1111_1111);
    add_req(dqs_pkg::ACT_PUSH_BACK, 32'h2222_2222);
    add_req(dqs_pkg::ACT_SEARCH, 32'h5A5A_000B);

    add_random_reqs(230);
    while (pending_reqs.size() != 0) @(posedge clk);
    src_idle_pct = 82;
    snk_idle_pct = 11;
    add_random_reqs(250);
    while (pending_reqs.size() != 0) @(posedge clk);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    add_random_reqs(250);

    while (pending_reqs.size() != 0 || req_ch.valid || expected_rsps.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
    if (err_count == 0 && expected_rsps.size() == 0 && pending_reqs.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/dqs_pkg.sv
hw/rtl/dqs_if.sv
hw/rtl/dqs_ram.sv
hw/rtl/double_ended_queue_with_search.sv
test/tb_double_ended_queue_with_search.sv
